// ===== rtl/fra_pkg.sv =====
// shared types and constants for the fraction reduce and add unit
package fra_pkg;

  // command codes
  localparam logic CMD_MAKE = 1'b0;
  localparam logic CMD_ADD  = 1'b1;

  // shared adder operation
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STRIP,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_DONE
  } st_e;

endpackage

// ===== rtl/fraction_reduce_and_add.sv =====
// top level of the fraction reduce and add unit: sequencer and datapath
// A request is taken when start_i is high while busy_o is low; busy_o then stays
// high until the single result has been shown. The result stands on num_out_o,
// den_out_o and is_empty_o for exactly one cycle with done_o high, and cannot be
// held off. All arithmetic goes through one 2*VALUE_BITS-bit adder/subtractor,
// one step per cycle. Make runs a binary gcd (common power-of-two strip, then
// shift and subtract steps) and then two restoring divisions, one per term;
// add runs three shift-add multiplies, two for the cross sum and one for the
// denominator product. A request with a non-positive operand among those that
// its command uses gives the empty fraction 0/1 in the cycle right after it is
// taken.
module fraction_reduce_and_add import fra_pkg::*; #(
  parameter int VALUE_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic                      command_i,
  input  logic [VALUE_BITS-1:0]     num_a_i,
  input  logic [VALUE_BITS-1:0]     den_a_i,
  input  logic [VALUE_BITS-1:0]     num_b_i,
  input  logic [VALUE_BITS-1:0]     den_b_i,
  output logic                      done_o,
  output logic [2*VALUE_BITS-2:0]   num_out_o,
  output logic [2*VALUE_BITS-3:0]   den_out_o,
  output logic                      is_empty_o
);

  localparam int VB = VALUE_BITS;
  localparam int MB = VB - 1;          // magnitude bits of a positive operand
  localparam int W  = 2 * VB;          // datapath width
  localparam int NW = 2 * VB - 1;
  localparam int DW = 2 * VB - 2;
  localparam int CW = $clog2(MB);      // step counter and power-of-two count

  st_e state_q, state_d;

  logic [W-1:0]  x_q, x_d;
  logic [W-1:0]  y_q, y_d;
  logic [W-1:0]  acc_q, acc_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] k_q, k_d;
  logic [MB-1:0] na_q, na_d;
  logic [MB-1:0] da_q, da_d;
  logic [MB-1:0] nb_q, nb_d;
  logic [MB-1:0] db_q, db_d;
  logic [NW-1:0] num_res_q, num_res_d;
  logic [DW-1:0] den_res_q, den_res_d;
  logic          empty_q, empty_d;

  // operand checks
  logic pos_na, pos_da, pos_nb, pos_db;
  logic make_ok, add_ok, last_step;

  assign pos_na = (num_a_i != '0) && !num_a_i[VB-1];
  assign pos_da = (den_a_i != '0) && !den_a_i[VB-1];
  assign pos_nb = (num_b_i != '0) && !num_b_i[VB-1];
  assign pos_db = (den_b_i != '0) && !den_b_i[VB-1];
  assign make_ok = pos_na && pos_da;
  assign add_ok  = pos_na && pos_da && pos_nb && pos_db;
  assign last_step = (cnt_q == CW'(MB - 1));

  // shared adder operand selection
  alu_op_e       alu_op;
  logic [W-1:0]  alu_a, alu_b, alu_res;
  logic          alu_carry;
  logic [W-1:0]  div_t;
  logic [MB-1:0] quo_next;

  assign div_t = {acc_q[W-2:0], x_q[MB-1]};
  assign quo_next = {x_q[MB-2:0], alu_carry};

  always_comb begin
    alu_op = ALU_SUB;
    alu_a  = x_q;
    alu_b  = y_q;
    case (state_q)
      ST_DIVN, ST_DIVD: begin
        alu_a = div_t;
        alu_b = y_q;
      end
      ST_MUL1, ST_MUL2, ST_MUL3: begin
        alu_op = ALU_ADD;
        alu_a  = acc_q;
        alu_b  = y_q[0] ? x_q : '0;
      end
      default: begin
        alu_op = ALU_SUB;
      end
    endcase
  end

  fra_alu #(
    .W (W)
  ) u_alu (
    .op_i    (alu_op),
    .a_i     (alu_a),
    .b_i     (alu_b),
    .res_o   (alu_res),
    .carry_o (alu_carry)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (command_i == CMD_MAKE) begin
            state_d = make_ok ? ST_STRIP : ST_DONE;
          end else begin
            state_d = add_ok ? ST_MUL1 : ST_DONE;
          end
        end
      end
      ST_STRIP: begin
        if (x_q[0] || y_q[0]) state_d = ST_GCD;
      end
      ST_GCD: begin
        if (x_q == '0) state_d = ST_DIVN;
      end
      ST_DIVN: if (last_step) state_d = ST_DIVD;
      ST_DIVD: if (last_step) state_d = ST_DONE;
      ST_MUL1: if (last_step) state_d = ST_MUL2;
      ST_MUL2: if (last_step) state_d = ST_MUL3;
      ST_MUL3: if (last_step) state_d = ST_DONE;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath updates per state
  always_comb begin
    x_d       = x_q;
    y_d       = y_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    k_d       = k_q;
    na_d      = na_q;
    da_d      = da_q;
    nb_d      = nb_q;
    db_d      = db_q;
    num_res_d = num_res_q;
    den_res_d = den_res_q;
    empty_d   = empty_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          na_d      = num_a_i[MB-1:0];
          da_d      = den_a_i[MB-1:0];
          nb_d      = num_b_i[MB-1:0];
          db_d      = den_b_i[MB-1:0];
          k_d       = '0;
          cnt_d     = '0;
          acc_d     = '0;
          num_res_d = '0;
          den_res_d = DW'(1);
          empty_d   = 1'b1;
          if (command_i == CMD_MAKE) begin
            x_d = W'(num_a_i[MB-1:0]);
            y_d = W'(den_a_i[MB-1:0]);
          end else begin
            x_d = W'(num_a_i[MB-1:0]);
            y_d = W'(den_b_i[MB-1:0]);
          end
        end
      end
      ST_STRIP: begin
        // drop common factors of two
        if (!(x_q[0] || y_q[0])) begin
          x_d = x_q >> 1;
          y_d = y_q >> 1;
          k_d = k_q + CW'(1);
        end
      end
      ST_GCD: begin
        if (x_q == '0) begin
          // gcd is the odd part times the stripped power of two
          y_d   = y_q << k_q;
          x_d   = W'(na_q);
          acc_d = '0;
          cnt_d = '0;
        end else if (!x_q[0]) begin
          x_d = x_q >> 1;
        end else if (!y_q[0]) begin
          y_d = y_q >> 1;
        end else if (alu_carry) begin
          x_d = alu_res;
        end else begin
          x_d = y_q;
          y_d = x_q;
        end
      end
      ST_DIVN, ST_DIVD: begin
        // restoring division step
        acc_d = alu_carry ? alu_res : div_t;
        x_d   = {x_q[W-2:0], alu_carry};
        cnt_d = cnt_q + CW'(1);
        if (last_step) begin
          cnt_d = '0;
          if (state_q == ST_DIVN) begin
            num_res_d = NW'(quo_next);
            x_d       = W'(da_q);
            acc_d     = '0;
          end else begin
            den_res_d = DW'(quo_next);
            empty_d   = 1'b0;
          end
        end
      end
      ST_MUL1, ST_MUL2, ST_MUL3: begin
        // shift-add multiply step
        acc_d = alu_res;
        x_d   = x_q << 1;
        y_d   = y_q >> 1;
        cnt_d = cnt_q + CW'(1);
        if (last_step) begin
          cnt_d = '0;
          case (state_q)
            ST_MUL1: begin
              x_d = W'(da_q);
              y_d = W'(nb_q);
            end
            ST_MUL2: begin
              num_res_d = alu_res[NW-1:0];
              acc_d     = '0;
              x_d       = W'(da_q);
              y_d       = W'(db_q);
            end
            default: begin
              den_res_d = alu_res[DW-1:0];
              empty_d   = 1'b0;
            end
          endcase
        end
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    x_q       <= x_d;
    y_q       <= y_d;
    acc_q     <= acc_d;
    na_q      <= na_d;
    da_q      <= da_d;
    nb_q      <= nb_d;
    db_q      <= db_d;
    num_res_q <= num_res_d;
    den_res_q <= den_res_d;
    empty_q   <= empty_d;
  end

  // handshake and result ports
  assign busy_o     = (state_q != ST_IDLE);
  assign done_o     = (state_q == ST_DONE);
  assign num_out_o  = num_res_q;
  assign den_out_o  = den_res_q;
  assign is_empty_o = empty_q;

`ifndef SYNTHESIS
  // an empty result is exactly 0/1
  a_empty_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && is_empty_o |-> (num_out_o == '0) && (den_out_o == DW'(1)))
    else $error("empty result is not 0/1");

  // a real result has nonzero numerator and denominator
  a_valid_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !is_empty_o |-> (num_out_o != '0) && (den_out_o != '0))
    else $error("non-empty result has a zero part");

  // one strobe per request, then back to idle
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy_o)
    else $error("result strobe longer than one cycle");

  // a taken request makes the unit busy
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("request taken but unit not busy");
`endif

endmodule

// ===== rtl/fra_alu.sv =====
// shared add and subtract unit with carry out
module fra_alu import fra_pkg::*; #(
  parameter int W = 32
) (
  input  alu_op_e        op_i,
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  output logic [W-1:0]   res_o,
  output logic           carry_o
);

  logic [W:0]   sum;
  logic [W-1:0] b_eff;

  // subtract as a plus inverted b plus one; carry set means no borrow
  always_comb begin
    b_eff = (op_i == ALU_SUB) ? ~b_i : b_i;
    sum   = {1'b0, a_i} + {1'b0, b_eff} + {{W{1'b0}}, (op_i == ALU_SUB)};
  end

  assign res_o   = sum[W-1:0];
  assign carry_o = sum[W];

endmodule

// ===== tb/fra_checker.sv =====
// request and result monitor with fraction predictor for the reduce and add unit
`timescale 1ns / 100ps

module fra_checker import fra_pkg::*; #(
  parameter int VALUE_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic                    busy_i,
  input  logic                    command_i,
  input  logic [VALUE_BITS-1:0]   num_a_i,
  input  logic [VALUE_BITS-1:0]   den_a_i,
  input  logic [VALUE_BITS-1:0]   num_b_i,
  input  logic [VALUE_BITS-1:0]   den_b_i,
  input  logic                    done_i,
  input  logic [2*VALUE_BITS-2:0] num_out_i,
  input  logic [2*VALUE_BITS-3:0] den_out_i,
  input  logic                    is_empty_i,
  output int                      errors_o,
  output int                      pending_o
);

  localparam int VB = VALUE_BITS;

  typedef struct packed {
    logic [2*VB-2:0] num;
    logic [2*VB-3:0] den;
    logic            empty;
  } fraction_t;

  fraction_t expected_fractions[$];
  int        mismatches = 0;

  // strictly positive: nonzero with the sign bit clear
  function automatic logic is_positive(logic [VB-1:0] v);
    return (v != '0) && !v[VB-1];
  endfunction

  // expected fraction for one request
  function automatic fraction_t fraction_result(logic cmd, logic [VB-1:0] na,
                                                logic [VB-1:0] da, logic [VB-1:0] nb,
                                                logic [VB-1:0] db);
    fraction_t       r;
    logic [VB-1:0]   g;
    logic [VB-1:0]   x;
    logic [VB-1:0]   t;
    logic [2*VB-1:0] cross_sum;
    logic [2*VB-1:0] den_prod;
    r.num   = '0;
    r.den   = (2*VB-2)'(1);
    r.empty = 1'b1;
    if (cmd == CMD_MAKE) begin
      if (is_positive(na) && is_positive(da)) begin
        // euclid gcd, then reduce both terms
        g = na;
        x = da;
        while (x != '0) begin
          t = g % x;
          g = x;
          x = t;
        end
        r.num   = (2*VB-1)'(na / g);
        r.den   = (2*VB-2)'(da / g);
        r.empty = 1'b0;
      end
    end else if (is_positive(na) && is_positive(da) &&
                 is_positive(nb) && is_positive(db)) begin
      // unreduced sum over the product of denominators
      cross_sum = (2*VB)'(na) * (2*VB)'(db) + (2*VB)'(da) * (2*VB)'(nb);
      den_prod  = (2*VB)'(da) * (2*VB)'(db);
      r.num     = cross_sum[2*VB-2:0];
      r.den     = den_prod[2*VB-3:0];
      r.empty   = 1'b0;
    end
    return r;
  endfunction

  // compare results first, then record newly taken requests
  always @(posedge clk_i) begin
    fraction_t want;
    if (rst_ni) begin
      if (done_i) begin
        if (expected_fractions.size() == 0) begin
          $error("result with no request outstanding: num_out %0d den_out %0d is_empty %0d",
                 num_out_i, den_out_i, is_empty_i);
          mismatches++;
        end else begin
          want = expected_fractions.pop_front();
          if (num_out_i !== want.num) begin
            $error("num_out: expected %0d, got %0d", want.num, num_out_i);
            mismatches++;
          end
          if (den_out_i !== want.den) begin
            $error("den_out: expected %0d, got %0d", want.den, den_out_i);
            mismatches++;
          end
          if (is_empty_i !== want.empty) begin
            $error("is_empty: expected %0d, got %0d", want.empty, is_empty_i);
            mismatches++;
          end
        end
      end
      if (start_i && !busy_i) begin
        expected_fractions.push_back(fraction_result(command_i, num_a_i, den_a_i,
                                                     num_b_i, den_b_i));
      end
    end
    errors_o  <= mismatches;
    pending_o <= expected_fractions.size();
  end

endmodule

// ===== tb/tb_fraction_reduce_and_add.sv =====
// stimulus, clock, reset and verdict for the fraction reduce and add unit
`timescale 1ns / 100ps

module tb_fraction_reduce_and_add import fra_pkg::*;;

  localparam int VB         = 16;
  localparam int NUM_RANDOM = 1950;

  logic            clk_i     = 1'b0;
  logic            rst_ni    = 1'b0;
  logic            start_i   = 1'b0;
  logic            command_i = CMD_MAKE;
  logic [VB-1:0]   num_a_i   = '0;
  logic [VB-1:0]   den_a_i   = '0;
  logic [VB-1:0]   num_b_i   = '0;
  logic [VB-1:0]   den_b_i   = '0;
  logic            busy_o;
  logic            done_o;
  logic [2*VB-2:0] num_out_o;
  logic [2*VB-3:0] den_out_o;
  logic            is_empty_o;
  int              errors;
  int              pending;

  always #1 clk_i = ~clk_i;

  fraction_reduce_and_add #(.VALUE_BITS(VB)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .command_i  (command_i),
    .num_a_i    (num_a_i),
    .den_a_i    (den_a_i),
    .num_b_i    (num_b_i),
    .den_b_i    (den_b_i),
    .done_o     (done_o),
    .num_out_o  (num_out_o),
    .den_out_o  (den_out_o),
    .is_empty_o (is_empty_o)
  );

  fra_checker #(.VALUE_BITS(VB)) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_i     (busy_o),
    .command_i  (command_i),
    .num_a_i    (num_a_i),
    .den_a_i    (den_a_i),
    .num_b_i    (num_b_i),
    .den_b_i    (den_b_i),
    .done_i     (done_o),
    .num_out_i  (num_out_o),
    .den_out_i  (den_out_o),
    .is_empty_i (is_empty_o),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  // idle cycles drawn one by one, then hold the request until the unit takes it
  task automatic send_request(input logic cmd, input logic [VB-1:0] na,
                              input logic [VB-1:0] da, input logic [VB-1:0] nb,
                              input logic [VB-1:0] db, input int gap_pct);
    while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i   <= 1'b1;
    command_i <= cmd;
    num_a_i   <= na;
    den_a_i   <= da;
    num_b_i   <= nb;
    den_b_i   <= db;
    do @(posedge clk_i); while (busy_o);
  endtask

  // mostly positive operands, with extremes and arbitrary bit patterns mixed in
  function automatic logic [VB-1:0] pick_operand();
    case ($urandom_range(15))
      0, 1: return VB'($urandom);
      2: begin
        case ($urandom_range(4))
          0: return '0;
          1: return VB'(1);
          2: return {1'b0, {(VB-1){1'b1}}};
          3: return {1'b1, {(VB-1){1'b0}}};
          default: return '1;
        endcase
      end
      3: return VB'(1) << $urandom_range(0, VB-2);
      4, 5: return VB'($urandom_range(1, 20));
      default: return VB'($urandom_range(1, 2**(VB-1)-1));
    endcase
  endfunction

  initial begin
    logic          cmd;
    logic [VB-1:0] na;
    logic [VB-1:0] da;
    logic [VB-1:0] nb;
    logic [VB-1:0] db;
    int            f;
    int            gap_pct;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: make extremes, gcd cases, non-positive operands, ignored b
    send_request(CMD_MAKE, 16'd1, 16'd1, 16'd0, 16'd0, 0);
    send_request(CMD_MAKE, 16'h7fff, 16'h7fff, 16'hffff, 16'h8000, 0);
    send_request(CMD_MAKE, 16'h7fff, 16'd1, 16'h1234, 16'h4321, 0);
    send_request(CMD_MAKE, 16'd1, 16'h7fff, 16'd0, 16'd0, 0);
    send_request(CMD_MAKE, 16'd12, 16'd18, 16'd7, 16'd9, 0);
    send_request(CMD_MAKE, 16'h4000, 16'h6000, 16'd0, 16'd0, 0);
    send_request(CMD_MAKE, 16'd32760, 16'd24, 16'd0, 16'd0, 0);
    send_request(CMD_MAKE, 16'd0, 16'd5, 16'd1, 16'd1, 0);
    send_request(CMD_MAKE, 16'd5, 16'd0, 16'd1, 16'd1, 0);
    send_request(CMD_MAKE, 16'hffff, 16'd5, 16'd1, 16'd1, 0);
    send_request(CMD_MAKE, 16'd5, 16'h8000, 16'd1, 16'd1, 0);
    // directed: add extremes and each operand non-positive in turn
    send_request(CMD_ADD, 16'd1, 16'd1, 16'd1, 16'd1, 0);
    send_request(CMD_ADD, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 0);
    send_request(CMD_ADD, 16'd1, 16'd2, 16'd1, 16'd3, 0);
    send_request(CMD_ADD, 16'h7fff, 16'd1, 16'h7fff, 16'd1, 0);
    send_request(CMD_ADD, 16'd0, 16'd3, 16'd4, 16'd5, 0);
    send_request(CMD_ADD, 16'd2, 16'd0, 16'd4, 16'd5, 0);
    send_request(CMD_ADD, 16'd2, 16'd3, 16'd0, 16'd5, 0);
    send_request(CMD_ADD, 16'd2, 16'd3, 16'd4, 16'd0, 0);
    send_request(CMD_ADD, 16'h8000, 16'd3, 16'd4, 16'd5, 0);
    send_request(CMD_ADD, 16'd2, 16'hffff, 16'd4, 16'd5, 0);
    send_request(CMD_ADD, 16'd2, 16'd3, 16'hc000, 16'd5, 0);
    send_request(CMD_ADD, 16'd2, 16'd3, 16'd4, 16'h8001, 0);

    // random: sender idles 14 then 80 percent, then not at all
    for (int i = 0; i < NUM_RANDOM; i++) begin
      case (i * 3 / NUM_RANDOM)
        0: gap_pct = 14;
        1: gap_pct = 80;
        default: gap_pct = 0;
      endcase
      cmd = $urandom_range(1) ? CMD_ADD : CMD_MAKE;
      na  = pick_operand();
      da  = pick_operand();
      nb  = pick_operand();
      db  = pick_operand();
      // shared factor so that make has real reduction work
      if (cmd == CMD_MAKE && $urandom_range(2) == 0) begin
        f  = $urandom_range(2, 181);
        na = VB'(f * $urandom_range(1, (2**(VB-1)-1) / f));
        da = VB'(f * $urandom_range(1, (2**(VB-1)-1) / f));
      end
      send_request(cmd, na, da, nb, db, gap_pct);
    end
    start_i <= 1'b0;

    // drain, then allow for a stray late result
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // hang guard
  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/fra_pkg.sv
rtl/fra_alu.sv
rtl/fraction_reduce_and_add.sv
tb/fra_checker.sv
tb/tb_fraction_reduce_and_add.sv
